[hw/rtl/deque_with_membership_search_macros.svh]
// Assertion macros for the deque with membership search.
`ifndef DEQUE_WITH_MEMBERSHIP_SEARCH_MACROS_SVH
`define DEQUE_WITH_MEMBERSHIP_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define DQMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define DQMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQMS_ASSERT_IMPL(label, ante, cons, msg)
`define DQMS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/dqms_pkg.sv]
// Types, constants and slot arithmetic for the deque with membership search.
`default_nettype none
package dqms_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int OCC_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_DROP_FRONT = 3'd2,
        OP_DROP_BACK  = 3'd3,
        OP_SEARCH     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic             found;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    // (base + off) mod DEPTH, with base below DEPTH and off at most DEPTH
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // (base - 1) mod DEPTH
    function automatic logic [ADDR_W-1:0] slot_prev(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] res;
        if (base == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = base - ADDR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/dqms_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module dqms_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/deque_with_membership_search.sv]
// Top level: bounded deque of signed 32-bit values with a membership search.
//
// Usage:
//   Command channel: drive i_item (op, value) and raise start; the transfer
//   happens at a rising edge with start high and busy low. Ops: push front,
//   push back, drop front, drop back, search; other codes are no-ops.
//   Result channel: every transfer yields exactly one result on o_result,
//   valid for the single cycle in which o_strobe is high. The receiver
//   cannot hold results off; it must take them as they come.
//   Timing / throughput:
//     push, drop, no-op : result in the cycle after the transfer, and busy
//                         stays low, so one of these per cycle.
//     search            : one store read per cycle through the RAM's single
//                         read port, each entry compared in the cycle after
//                         its read, front to back. The walk ends at the
//                         first hit or after the last entry, and the result
//                         is registered then. busy is high meanwhile.
//                         A search of an empty deque answers like a push.
//   Reset (i_rst_n low, synchronous): front slot and count go to zero, the
//   state machine goes idle and no strobe is issued. The store is not
//   cleared; only slots between front and back are ever compared.
`default_nettype none
`include "deque_with_membership_search_macros.svh"
module deque_with_membership_search (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire dqms_pkg::t_item i_item,
    output logic                 o_strobe,
    output dqms_pkg::t_result    o_result
);

    // Control state
    dqms_pkg::t_state                r_state, n_state;
    logic [dqms_pkg::ADDR_W-1:0]     r_front, n_front;
    logic [dqms_pkg::CNT_W-1:0]      r_count, n_count;
    // Search walk: r_idx is the next offset to read, r_rd_vld marks RAM data
    logic [dqms_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic                            r_rd_vld, n_rd_vld;
    logic [dqms_pkg::DATA_W-1:0]     r_key, n_key;
    // Result register
    logic                            r_strobe, n_strobe;
    dqms_pkg::t_result               r_res, n_res;

    // Store port
    logic                            w_we;
    logic [dqms_pkg::ADDR_W-1:0]     w_waddr;
    logic [dqms_pkg::DATA_W-1:0]     w_wdata;
    logic [dqms_pkg::ADDR_W-1:0]     w_raddr;
    logic [dqms_pkg::DATA_W-1:0]     w_rdata;

    logic                            w_accept;
    logic                            w_full;
    logic                            w_empty;
    logic                            w_hit;
    logic                            w_miss_end;

    dqms_ram #(
        .DATA_W (dqms_pkg::DATA_W),
        .DEPTH  (dqms_pkg::DEPTH),
        .ADDR_W (dqms_pkg::ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy     = (r_state != dqms_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == dqms_pkg::CNT_W'(dqms_pkg::DEPTH));
    assign w_empty  = (r_count == '0);
    // Compare stage of the search walk
    assign w_hit      = r_rd_vld && (w_rdata == r_key);
    assign w_miss_end = r_rd_vld && (w_rdata != r_key) && (r_idx == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dqms_pkg::S_IDLE: begin
                if (w_accept && (i_item.op == dqms_pkg::OP_SEARCH) && !w_empty) begin
                    n_state = dqms_pkg::S_SEARCH;
                end
            end
            dqms_pkg::S_SEARCH: begin
                if (w_hit || w_miss_end) begin
                    n_state = dqms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dqms_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_key     = r_key;
        n_strobe  = 1'b0;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = dqms_pkg::slot_prev(r_front);
        w_wdata   = i_item.value;
        w_raddr   = dqms_pkg::slot_add(r_front, r_idx);

        case (r_state)
            dqms_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_res.found  = 1'b0;
                    n_res.status = dqms_pkg::ST_DONE;
                    n_strobe     = 1'b1;
                    case (i_item.op)
                        dqms_pkg::OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_res.status = dqms_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = dqms_pkg::slot_prev(r_front);
                                n_front = dqms_pkg::slot_prev(r_front);
                                n_count = r_count + dqms_pkg::CNT_W'(1);
                            end
                        end
                        dqms_pkg::OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_res.status = dqms_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = dqms_pkg::slot_add(r_front, r_count);
                                n_count = r_count + dqms_pkg::CNT_W'(1);
                            end
                        end
                        dqms_pkg::OP_DROP_FRONT: begin
                            if (w_empty) begin
                                n_res.status = dqms_pkg::ST_EMPTY;
                            end else begin
                                n_front = dqms_pkg::slot_add(r_front, dqms_pkg::CNT_W'(1));
                                n_count = r_count - dqms_pkg::CNT_W'(1);
                            end
                        end
                        dqms_pkg::OP_DROP_BACK: begin
                            if (w_empty) begin
                                n_res.status = dqms_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - dqms_pkg::CNT_W'(1);
                            end
                        end
                        dqms_pkg::OP_SEARCH: begin
                            // empty deque: answer now, nothing to read
                            if (!w_empty) begin
                                n_strobe = 1'b0;
                                n_key    = i_item.value;
                                n_idx    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.occupancy = dqms_pkg::OCC_W'(n_count);
                end
            end
            dqms_pkg::S_SEARCH: begin
                // issue stage: one read per cycle until every entry is out
                if (r_idx != r_count) begin
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + dqms_pkg::CNT_W'(1);
                end
                if (w_hit || w_miss_end) begin
                    n_strobe        = 1'b1;
                    n_rd_vld        = 1'b0;
                    n_res.found     = w_hit;
                    n_res.status    = dqms_pkg::ST_DONE;
                    n_res.occupancy = dqms_pkg::OCC_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dqms_pkg::S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `DQMS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= dqms_pkg::CNT_W'(dqms_pkg::DEPTH), "count above depth")
    `DQMS_ASSERT_NEXT(a_accept_answers, w_accept, r_strobe || busy, "transfer neither answered nor searching")
    `DQMS_ASSERT_IMPL(a_no_strobe_busy, r_strobe, !busy, "result strobed while search in progress")
    `DQMS_ASSERT_IMPL(a_found_done, r_strobe && r_res.found, r_res.status == dqms_pkg::ST_DONE, "found with bad status")
    `DQMS_ASSERT_IMPL(a_walk_bound, r_state == dqms_pkg::S_SEARCH, (r_idx <= r_count) && !w_empty, "search walk out of range")

endmodule
`default_nettype wire
